// File: sv/nsa_pkg.sv
// ----------------------------------------------------------------------------
// nsa_pkg
// Shared types and constants for the nearest-site lookup block: beat
// structs, register indexes, the site table geometry and scan tags.
// ----------------------------------------------------------------------------
`default_nettype none

package nsa_pkg;

	// site table geometry
	localparam int MAX_SITES  = 32;
	localparam int COORD_BITS = 12;
	localparam int ADDR_W     = $clog2(MAX_SITES);

	// field widths
	localparam int SLOT_W     = 5;
	localparam int INDEX_W    = 12;
	localparam int DIST_W     = 25;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 6;
	localparam int FRAME_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// register reset values
	localparam logic [MODE_W-1:0]  MODE_RST   = MODE_W'(2);
	localparam logic [COUNT_W-1:0] COUNT_RST  = COUNT_W'(20);
	localparam logic [FRAME_W-1:0] WIDTH_RST  = FRAME_W'(640);
	localparam logic [FRAME_W-1:0] HEIGHT_RST = FRAME_W'(480);

	// start modes; the unused code behaves as table mode
	typedef enum logic [MODE_W-1:0] {
		MODE_CENTER = 2'd0,
		MODE_BOTTOM = 2'd1,
		MODE_TABLE  = 2'd2,
		MODE_SPARE  = 2'd3
	} mode_e;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MODE   = 2'd0,
		CFG_SITE_COUNT   = 2'd1,
		CFG_FRAME_WIDTH  = 2'd2,
		CFG_FRAME_HEIGHT = 2'd3
	} cfg_reg_e;

	// input beat opcodes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic                  func;
		logic [SLOT_W-1:0]     slot;
		logic [COORD_BITS-1:0] point_x;
		logic [COORD_BITS-1:0] point_y;
	} in_beat_t;

	typedef struct packed {
		logic [INDEX_W-1:0] nearest_index;
		logic [DIST_W-1:0]  distance;
	} out_beat_t;

	// tag that travels with one site through the distance pipeline
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [ADDR_W-1:0] index;
	} scan_tag_t;

endpackage

`default_nettype wire

// File: sv/nsa_dist.sv
// ----------------------------------------------------------------------------
// nsa_dist
// Squaring stage of the distance pipeline: absolute coordinate differences
// between the query point and one site, squared and registered per axis.
// ----------------------------------------------------------------------------
`default_nettype none

module nsa_dist (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic [nsa_pkg::COORD_BITS-1:0] point_x,
	input  wire logic [nsa_pkg::COORD_BITS-1:0] point_y,
	input  wire logic [nsa_pkg::COORD_BITS-1:0] site_x,
	input  wire logic [nsa_pkg::COORD_BITS-1:0] site_y,
	input  wire nsa_pkg::scan_tag_t          tag_s1,
	output nsa_pkg::scan_tag_t               tag_s2,
	output logic [nsa_pkg::SQ_W-1:0]         dx2_s2,
	output logic [nsa_pkg::SQ_W-1:0]         dy2_s2
);

	logic [nsa_pkg::COORD_BITS-1:0] dx;
	logic [nsa_pkg::COORD_BITS-1:0] dy;

	// absolute differences
	always_comb begin
		dx = (point_x > site_x) ? (point_x - site_x) : (site_x - point_x);
		dy = (point_y > site_y) ? (point_y - site_y) : (site_y - point_y);
	end

	// squares, one multiplier per axis
	always_ff @(posedge clk) begin
		dx2_s2 <= nsa_pkg::SQ_W'(dx) * nsa_pkg::SQ_W'(dx);
		dy2_s2 <= nsa_pkg::SQ_W'(dy) * nsa_pkg::SQ_W'(dy);
	end

	// tag follows the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

endmodule

`default_nettype wire

// File: sv/nearest_site_assign.sv
// ----------------------------------------------------------------------------
// nearest_site_assign
// Nearest-site lookup over a small table of sites held in a synchronous
// memory. Loads write one site; queries return the nearest site and its
// distance in center, bottom-row or table mode.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_data  (func, slot, point_x, point_y)
//  out      output     out_valid/out_stall out_data (nearest_index, distance)
//  cfg      input      cfg_write           cfg_index, cfg_data
//
//  load beat: written into the site memory at the accept edge
//  table query: one memory read per site, then the read register, the
//  squaring stage and the compare; center query: one site, the frame center
//  bottom query: no memory access
//  a new beat is taken while a finished result still waits on out_stall
//  reset restores control and the configuration registers; the site memory is not cleared
//
`default_nettype none

module nearest_site_assign (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire nsa_pkg::in_beat_t               in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output nsa_pkg::out_beat_t                   out_data,
	input  wire                                  cfg_write,
	input  wire logic [nsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [nsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [nsa_pkg::MODE_W-1:0]  start_mode_q;
	logic [nsa_pkg::COUNT_W-1:0] site_count_q;
	logic [nsa_pkg::FRAME_W-1:0] frame_width_q;
	logic [nsa_pkg::FRAME_W-1:0] frame_height_q;

	// query context
	logic [nsa_pkg::COORD_BITS-1:0] point_x_q;
	logic [nsa_pkg::COORD_BITS-1:0] point_y_q;
	logic                           center_q;
	logic [nsa_pkg::ADDR_W-1:0]     scan_idx_q;
	logic [nsa_pkg::ADDR_W-1:0]     last_q;
	logic [nsa_pkg::ADDR_W-1:0]     last_d;

	// best candidate so far
	logic [nsa_pkg::INDEX_W-1:0] best_idx_q;
	logic [nsa_pkg::DIST_W-1:0]  best_dist_q;

	// site memory and pipeline
	logic [2*nsa_pkg::COORD_BITS-1:0] site_mem [nsa_pkg::MAX_SITES];
	logic [2*nsa_pkg::COORD_BITS-1:0] rd_data_s1;
	nsa_pkg::scan_tag_t               issue_tag;
	nsa_pkg::scan_tag_t               tag_s1;
	nsa_pkg::scan_tag_t               tag_s2;
	logic [nsa_pkg::COORD_BITS-1:0]   site_x_s1;
	logic [nsa_pkg::COORD_BITS-1:0]   site_y_s1;
	logic [nsa_pkg::SQ_W-1:0]         dx2_s2;
	logic [nsa_pkg::SQ_W-1:0]         dy2_s2;
	logic [nsa_pkg::DIST_W-1:0]       dist_s2;

	// output register
	nsa_pkg::out_beat_t out_q;
	logic               out_valid_q;

	logic in_fire;
	logic out_fire;
	logic load_fire;
	logic query_fire;
	logic is_bottom;
	logic is_center;
	logic [nsa_pkg::FRAME_W-1:0] bottom_dist;
	logic [nsa_pkg::COORD_BITS-1:0] center_x;
	logic [nsa_pkg::COORD_BITS-1:0] center_y;

	// handshakes
	assign in_stall   = (state_q != ST_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign load_fire  = in_fire && (in_data.func == nsa_pkg::FUNC_LOAD);
	assign query_fire = in_fire && (in_data.func == nsa_pkg::FUNC_QUERY);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign out_fire   = out_valid_q && !out_stall;

	assign is_bottom = (start_mode_q == nsa_pkg::MODE_BOTTOM);
	assign is_center = (start_mode_q == nsa_pkg::MODE_CENTER);
	assign center_x  = nsa_pkg::COORD_BITS'(frame_width_q >> 1);
	assign center_y  = nsa_pkg::COORD_BITS'(frame_height_q >> 1);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mode_q   <= nsa_pkg::MODE_RST;
			site_count_q   <= nsa_pkg::COUNT_RST;
			frame_width_q  <= nsa_pkg::WIDTH_RST;
			frame_height_q <= nsa_pkg::HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (nsa_pkg::cfg_reg_e'(cfg_index))
				nsa_pkg::CFG_START_MODE:   start_mode_q   <= nsa_pkg::MODE_W'(cfg_data);
				nsa_pkg::CFG_SITE_COUNT:   site_count_q   <= nsa_pkg::COUNT_W'(cfg_data);
				nsa_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				nsa_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last scanned entry: center mode and zero count scan one site, large counts saturate
	always_comb begin
		if (is_center || site_count_q == '0) begin
			last_d = '0;
		end else if (int'(site_count_q) > nsa_pkg::MAX_SITES) begin
			last_d = nsa_pkg::ADDR_W'(nsa_pkg::MAX_SITES - 1);
		end else begin
			last_d = nsa_pkg::ADDR_W'(site_count_q - 1'b1);
		end
	end

	// bottom mode distance, saturating at zero below the frame
	always_comb begin
		if ({1'b0, in_data.point_y} < frame_height_q) begin
			bottom_dist = frame_height_q - 1'b1 - {1'b0, in_data.point_y};
		end else begin
			bottom_dist = '0;
		end
	end

	// site memory: loads only in idle; reads are unconditional, but only scan reads carry a valid tag
	always_ff @(posedge clk) begin
		if (load_fire && (int'(in_data.slot) < nsa_pkg::MAX_SITES)) begin
			site_mem[nsa_pkg::ADDR_W'(in_data.slot)] <= {in_data.point_x, in_data.point_y};
		end
		rd_data_s1 <= site_mem[scan_idx_q];
	end

	// read issue tag
	always_comb begin
		issue_tag.valid = (state_q == ST_SCAN);
		issue_tag.last  = (scan_idx_q == last_q);
		issue_tag.index = scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= issue_tag;
		end
	end

	// center mode replaces the table entry with the frame center
	assign site_x_s1 = center_q ? center_x : rd_data_s1[2*nsa_pkg::COORD_BITS-1:nsa_pkg::COORD_BITS];
	assign site_y_s1 = center_q ? center_y : rd_data_s1[nsa_pkg::COORD_BITS-1:0];

	nsa_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.point_x (point_x_q),
		.point_y (point_y_q),
		.site_x  (site_x_s1),
		.site_y  (site_y_s1),
		.tag_s1  (tag_s1),
		.tag_s2  (tag_s2),
		.dx2_s2  (dx2_s2),
		.dy2_s2  (dy2_s2)
	);

	assign dist_s2 = nsa_pkg::DIST_W'(dx2_s2) + nsa_pkg::DIST_W'(dy2_s2);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					state_d = is_bottom ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tag_s2.valid && tag_s2.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			last_q     <= '0;
			center_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (query_fire) begin
				scan_idx_q <= '0;
				last_q     <= last_d;
				center_q   <= is_center;
			end else if (state_q == ST_SCAN && scan_idx_q != last_q) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// query point
	always_ff @(posedge clk) begin
		if (query_fire) begin
			point_x_q <= in_data.point_x;
			point_y_q <= in_data.point_y;
		end
	end

	// running minimum; strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (query_fire && is_bottom) begin
			best_idx_q  <= nsa_pkg::INDEX_W'(in_data.point_x);
			best_dist_q <= nsa_pkg::DIST_W'(bottom_dist);
		end else if (tag_s2.valid && (tag_s2.index == '0 || dist_s2 < best_dist_q)) begin
			best_idx_q  <= nsa_pkg::INDEX_W'(tag_s2.index);
			best_dist_q <= dist_s2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_q.nearest_index <= best_idx_q;
			out_q.distance      <= best_dist_q;
		end
	end

	// scan pipeline only carries sites while a query is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		tag_s2.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance pipeline busy outside a scan");

	// read address never runs past the last entry of the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q <= last_q))
		else $error("scan index beyond last entry");

	// a result appears only out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside done state");

	// the drain state is left only for the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DRAIN || state_q == ST_DONE))
		else $error("drain left without finishing");

endmodule

`default_nettype wire
